### hw/rtl/assert_macros.svh
// assertion macros used by the detector top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/tsod_pkg.sv
// types and constants for the two-sigma outlier detector
// no dependencies
package tsod_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DIV,
        ST_FIX,
        ST_SQ_RD,
        ST_SQ_ACC,
        ST_VDIV,
        ST_SQRT,
        ST_OUT_RD,
        ST_OUT
    } state_t;

    localparam int SUM_W    = 22;
    localparam int SUMSQ_W  = 40;

endpackage

### hw/rtl/two_sigma_outlier_detector.sv
// two-sigma outlier detector top level
// depends on tsod_pkg and assert_macros.svh
//
// usage: pulse start with sample and last while busy is low; one sample is
// transferred per accepted start. busy stays low while a set is loading, so
// samples can be given every cycle. a sample marked last, or the sample
// that fills the DEPTH-entry store, closes the set and raises busy.
// the block then divides the sum by the count (restoring divider, one bit a
// cycle), reads the store once to sum squared deviations (a read state then
// an accumulate state per sample, one memory read port), divides that sum by
// the count and takes a floor square root. it then reads the store again and
// gives one result per sample on consecutive strobes, index 0 first, with
// final_res on the last one, each result taking a read state then an output
// state. busy drops with the last result.
// the receiver cannot stall: each result is valid for one cycle with strobe.
// reset clears count, sum and control; store contents stay undefined and are
// never read before being written in the current set.
`include "assert_macros.svh"

module two_sigma_outlier_detector #(
    parameter int DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  sample,
    input  logic                last,
    output logic                strobe,
    output logic [5:0]          index,
    output logic signed [15:0]  reading,
    output logic                anomaly,
    output logic signed [15:0]  mean,
    output logic [31:0]         variance,
    output logic [15:0]         std_dev,
    output logic                final_res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [15:0] mem [DEPTH];
    logic signed [15:0] rd_data;
    logic [AW-1:0]      rd_addr;

    tsod_pkg::state_t state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic signed [tsod_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [AW-1:0]      ptr_reg, ptr_next;
    logic [6:0]         step_reg, step_next;
    logic [tsod_pkg::SUMSQ_W-1:0] quo_reg, quo_next;
    logic [tsod_pkg::SUMSQ_W:0]   rem_reg, rem_next;
    logic               neg_reg, neg_next;
    logic signed [15:0] mean_reg, mean_next;
    logic [tsod_pkg::SUMSQ_W-1:0] acc_reg, acc_next;
    logic [31:0]        var_reg, var_next;
    logic [33:0]        sq_rem_reg, sq_rem_next;
    logic [15:0]        root_reg, root_next;
    logic               strobe_reg, strobe_next;
    logic [5:0]         index_reg, index_next;
    logic signed [15:0] reading_reg, reading_next;
    logic               anomaly_reg, anomaly_next;
    logic               final_reg, final_next;

    logic               accept;
    logic               wr_en;
    logic signed [16:0] dev;
    logic [16:0]        adev;
    logic [33:0]        sq;
    logic [33:0]        trial;
    logic [tsod_pkg::SUMSQ_W:0] rem_sh;

    assign busy   = (state_reg != tsod_pkg::ST_LOAD);
    assign accept = start && !busy;
    assign wr_en  = accept;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= sample;
        end
        rd_data <= mem[rd_addr];
    end

    assign rd_addr = ptr_reg;
    assign dev     = 17'(rd_data) - 17'(mean_reg);
    assign adev    = dev[16] ? 17'(-dev) : 17'(dev);
    assign sq      = 34'(adev) * 34'(adev);
    assign rem_sh  = {rem_reg[tsod_pkg::SUMSQ_W-1:0], quo_reg[tsod_pkg::SUMSQ_W-1]};
    assign trial   = {sq_rem_reg[31:0], var_reg[31:30]} - {16'd0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tsod_pkg::ST_LOAD;
            count_reg  <= '0;
            sum_reg    <= '0;
            ptr_reg    <= '0;
            step_reg   <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            ptr_reg    <= ptr_next;
            step_reg   <= step_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        mean_reg    <= mean_next;
        acc_reg     <= acc_next;
        var_reg     <= var_next;
        sq_rem_reg  <= sq_rem_next;
        root_reg    <= root_next;
        index_reg   <= index_next;
        reading_reg <= reading_next;
        anomaly_reg <= anomaly_next;
        final_reg   <= final_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        ptr_next     = ptr_reg;
        step_next    = step_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        mean_next    = mean_reg;
        acc_next     = acc_reg;
        var_next     = var_reg;
        sq_rem_next  = sq_rem_reg;
        root_next    = root_reg;
        strobe_next  = 1'b0;
        index_next   = index_reg;
        reading_next = reading_reg;
        anomaly_next = anomaly_reg;
        final_next   = final_reg;
        unique case (state_reg)
            tsod_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + tsod_pkg::SUM_W'(sample);
                    if (last || (count_reg == CW'(DEPTH - 1)))
                    begin
                        neg_next   = sum_next[tsod_pkg::SUM_W-1];
                        quo_next   = sum_next[tsod_pkg::SUM_W-1]
                                     ? -tsod_pkg::SUMSQ_W'(sum_next)
                                     : tsod_pkg::SUMSQ_W'(sum_next);
                        rem_next   = '0;
                        step_next  = 7'(tsod_pkg::SUMSQ_W);
                        state_next = tsod_pkg::ST_DIV;
                    end
                end
            end
            tsod_pkg::ST_DIV,
            tsod_pkg::ST_VDIV:
            begin
                if (rem_sh >= (tsod_pkg::SUMSQ_W + 1)'(count_reg))
                begin
                    rem_next = rem_sh - (tsod_pkg::SUMSQ_W + 1)'(count_reg);
                    quo_next = {quo_reg[tsod_pkg::SUMSQ_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[tsod_pkg::SUMSQ_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == 7'd1)
                begin
                    state_next = (state_reg == tsod_pkg::ST_DIV)
                                 ? tsod_pkg::ST_FIX : tsod_pkg::ST_SQRT;
                end
            end
            tsod_pkg::ST_FIX:
            begin
                mean_next  = neg_reg ? 16'(-quo_reg) : 16'(quo_reg);
                acc_next   = '0;
                ptr_next   = '0;
                state_next = tsod_pkg::ST_SQ_RD;
            end
            tsod_pkg::ST_SQ_RD:
            begin
                state_next = tsod_pkg::ST_SQ_ACC;
            end
            tsod_pkg::ST_SQ_ACC:
            begin
                acc_next = acc_reg + tsod_pkg::SUMSQ_W'(sq);
                if (CW'(ptr_reg) == count_reg - 1'b1)
                begin
                    quo_next   = acc_next;
                    rem_next   = '0;
                    step_next  = 7'(tsod_pkg::SUMSQ_W);
                    state_next = tsod_pkg::ST_VDIV;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = tsod_pkg::ST_SQ_RD;
                end
            end
            tsod_pkg::ST_SQRT:
            begin
                if (step_reg == 7'd0)
                begin
                    var_next    = (quo_reg > 40'hFFFFFFFF) ? 32'hFFFFFFFF : quo_reg[31:0];
                    sq_rem_next = '0;
                    root_next   = '0;
                    step_next   = 7'd16;
                end
                else
                begin
                    if (!trial[33])
                    begin
                        sq_rem_next = trial;
                        root_next   = {root_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        sq_rem_next = {sq_rem_reg[31:0], var_reg[31:30]};
                        root_next   = {root_reg[14:0], 1'b0};
                    end
                    var_next  = {var_reg[29:0], 2'b00};
                    step_next = step_reg - 1'b1;
                    if (step_reg == 7'd1)
                    begin
                        var_next   = (quo_reg > 40'hFFFFFFFF) ? 32'hFFFFFFFF : quo_reg[31:0];
                        ptr_next   = '0;
                        state_next = tsod_pkg::ST_OUT_RD;
                    end
                end
            end
            tsod_pkg::ST_OUT_RD:
            begin
                state_next = tsod_pkg::ST_OUT;
            end
            tsod_pkg::ST_OUT:
            begin
                strobe_next  = 1'b1;
                index_next   = 6'(ptr_reg);
                reading_next = rd_data;
                anomaly_next = ({1'b0, adev} > {1'b0, root_reg, 1'b0});
                final_next   = (CW'(ptr_reg) == count_reg - 1'b1);
                if (final_next)
                begin
                    count_next = '0;
                    sum_next   = '0;
                    state_next = tsod_pkg::ST_LOAD;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    state_next = tsod_pkg::ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = tsod_pkg::ST_LOAD;
            end
        endcase
    end

    assign strobe    = strobe_reg;
    assign index     = index_reg;
    assign reading   = reading_reg;
    assign anomaly   = anomaly_reg;
    assign mean      = mean_reg;
    assign variance  = var_reg;
    assign std_dev   = root_reg;
    assign final_res = final_reg;

    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, busy, !accept)
    `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH))
    `ASSERT_NEXT(a_final_idle, clk, rst_n, strobe_next && final_next, !busy)
    `ASSERT_IMPL(a_strobe_busy, clk, rst_n, strobe && !final_res, busy)

endmodule
